// ----- rtl/core/sobel_pkg.sv -----
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared codes, types and the integer square root steps used by the
// Sobel edge magnitude pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sobel_pkg;

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [10:0] WIDTH_RESET  = 11'd1024;
	localparam logic [12:0] HEIGHT_RESET = 13'd768;
	localparam logic [12:0] HEIGHT_LIMIT = 13'd4096;

	localparam logic [20:0] SAT_LEVEL = 21'd65281;

	typedef logic [23:0] rgb_t;
	typedef logic signed [10:0] grad_t;

	// Four digit-by-digit root steps on a 16-bit value: {remainder, partial root}.
	// The upper half starts at bit 14, the lower half continues at bit 6.
	function automatic logic [33:0] isqrt_half(input logic [16:0] rem_in,
		input logic [16:0] res_in, input logic upper);
		logic [16:0] rem;
		logic [16:0] res;
		logic [16:0] bitv;
		rem = rem_in;
		res = res_in;
		bitv = upper ? 17'h04000 : 17'h00040;
		for (int i = 0; i < 4; i++) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return {rem, res};
	endfunction

	// Finish the root: {remainder[8:0], root[7:0]}
	function automatic logic [16:0] isqrt_lower(input logic [33:0] part);
		logic [33:0] t;
		t = isqrt_half(part[33:17], part[16:0], 1'b0);
		return {t[25:17], t[7:0]};
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sobel_edge_magnitude_rgb.sv -----
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb
// Streaming 3x3 Sobel magnitude on RGB words with a line memory and window.
// ----------------------------------------------------------------------------
// Path: the input word that completes a neighborhood passes the read stage,
// the window, the magnitude unit and the output register; all hold on a stall.
// Throughput: one word per cycle unless the output stalls; the line memory is
// read at accept and written back as the word advances, forwarding on repeats.
// Reset: positions clear, registers load width 1024 and height 768; line
// memory contents are never seen outside the image and need no clearing.
`default_nettype none

module sobel_edge_magnitude_rgb
	import sobel_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
)
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        action,
	input  wire logic [7:0]  red_in,
	input  wire logic [7:0]  green_in,
	input  wire logic [7:0]  blue_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       red_out,
	output logic [7:0]       green_out,
	output logic [7:0]       blue_out,
	output logic             frame_last,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);

	logic [10:0]      width_q;
	logic [12:0]      height_q;
	logic [COL_W-1:0] col_q;
	logic [12:0]      row_q;

	logic             cfg_wr;
	logic             adv;
	logic             acc;

	logic [WW-1:0]    w_eff;
	logic [12:0]      h_eff;
	logic [COL_W-1:0] c0;
	logic [COL_W-1:0] ocol;
	logic [12:0]      orow;
	logic             have;
	logic             last;
	logic [2:0]       rowok;
	logic [2:0]       colok;
	rgb_t             pix;

	logic [47:0]      line_mem [MAX_WIDTH];
	logic [47:0]      rd_q;

	logic             v_s1;
	logic [COL_W-1:0] c_s1;
	rgb_t             pix_s1;
	logic             have_s1;
	logic             last_s1;
	logic [2:0]       rowok_s1;
	logic [2:0]       colok_s1;
	logic             fwd_s1;
	logic [47:0]      fwd_q;
	rgb_t             top_e;
	rgb_t             mid_e;

	rgb_t             win_q [9];
	logic             have_s2;
	logic             last_s2;
	logic [2:0]       rowok_s2;
	logic [2:0]       colok_s2;
	logic [3:0]       have_q;
	logic [3:0]       last_q;

	grad_t            gx [3];
	grad_t            gy [3];
	logic [7:0]       mag [3];

	logic             out_valid_q;
	logic             out_last_q;
	logic [7:0]       red_q;
	logic [7:0]       green_q;
	logic [7:0]       blue_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		case (paddr[2])
			REG_WIDTH:  prdata = {21'd0, width_q};
			REG_HEIGHT: prdata = {19'd0, height_q};
			default:    prdata = '0;
		endcase
	end

	// stream control
	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;
	assign acc      = in_valid && adv;

	always_comb begin
		if (width_q == 11'd0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q == 13'd0) begin
			h_eff = 13'd1;
		end else if (height_q > HEIGHT_LIMIT) begin
			h_eff = HEIGHT_LIMIT;
		end else begin
			h_eff = height_q;
		end
		c0 = (WW'(col_q) >= w_eff) ? '0 : col_q;
		have = 1'b0;
		orow = '0;
		ocol = '0;
		if (c0 != '0 && row_q != '0) begin
			have = 1'b1;
			orow = row_q - 13'd1;
			ocol = c0 - COL_W'(1);
		end else if (c0 == '0 && row_q >= 13'd2) begin
			have = 1'b1;
			orow = row_q - 13'd2;
			ocol = COL_W'(w_eff - WW'(1));
		end
		if (orow >= h_eff) begin
			have = 1'b0;
		end
		last = have && (orow == h_eff - 13'd1) && (ocol == COL_W'(w_eff - WW'(1)));
		rowok[0] = (orow != '0);
		rowok[1] = 1'b1;
		rowok[2] = ({1'b0, orow} + 14'd1) < {1'b0, h_eff};
		colok[0] = (ocol != '0);
		colok[1] = 1'b1;
		colok[2] = ({1'b0, WW'(ocol)} + (WW + 1)'(1)) < {1'b0, w_eff};
		pix = (action == ACT_FLUSH) ? '0 : {red_in, green_in, blue_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[10:0];
				REG_HEIGHT: height_q <= pwdata[12:0];
				default:    width_q  <= width_q;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (WW'(c0) + WW'(1) >= w_eff) begin
				col_q <= '0;
				row_q <= row_q + 13'd1;
			end else begin
				col_q <= c0 + COL_W'(1);
			end
		end
	end

	// line memory: upper half holds the row above the middle row
	assign {top_e, mid_e} = fwd_s1 ? fwd_q : rd_q;

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			line_mem[c_s1] <= {mid_e, pix_s1};
		end
		if (acc) begin
			rd_q <= line_mem[c0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			have_s2 <= 1'b0;
			have_q  <= '0;
		end else if (adv) begin
			v_s1    <= acc;
			have_s2 <= v_s1 && have_s1;
			have_q  <= {have_q[2:0], have_s2};
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			c_s1     <= c0;
			pix_s1   <= pix;
			have_s1  <= have;
			last_s1  <= last;
			rowok_s1 <= rowok;
			colok_s1 <= colok;
			// same entry as the write in flight: take the written word instead
			fwd_s1   <= v_s1 && (c_s1 == c0);
			fwd_q    <= {mid_e, pix_s1};
		end
		if (adv && v_s1) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k]     <= win_q[3 + k];
				win_q[3 + k] <= win_q[6 + k];
			end
			win_q[6] <= top_e;
			win_q[7] <= mid_e;
			win_q[8] <= pix_s1;
			last_s2  <= last_s1;
			rowok_s2 <= rowok_s1;
			colok_s2 <= colok_s1;
		end
		if (adv) begin
			last_q <= {last_q[2:0], last_s2};
		end
	end

	// Sobel sums per channel with out-of-image taps zeroed
	always_comb begin
		logic [10:0] p [3][3];
		for (int ch = 0; ch < 3; ch++) begin
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++) begin
					p[k][j] = (rowok_s2[k] && colok_s2[j])
						? {3'd0, win_q[j * 3 + k][(16 - 8 * ch) +: 8]} : 11'd0;
				end
			end
			gx[ch] = $signed((p[0][2] + (p[1][2] << 1) + p[2][2])
				- (p[0][0] + (p[1][0] << 1) + p[2][0]));
			gy[ch] = $signed((p[2][0] + (p[2][1] << 1) + p[2][2])
				- (p[0][0] + (p[0][1] << 1) + p[0][2]));
		end
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_mag
		sobel_mag u_mag (
			.clk (clk),
			.en  (adv),
			.gx  (gx[ch]),
			.gy  (gy[ch]),
			.mag (mag[ch])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= have_q[3];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red_q      <= mag[0];
			green_q    <= mag[1];
			blue_q     <= mag[2];
			out_last_q <= last_q[3];
		end
	end

	assign out_valid  = out_valid_q;
	assign red_out    = red_q;
	assign green_out  = green_q;
	assign blue_out   = blue_q;
	assign frame_last = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/core/sobel_mag.sv -----
// ----------------------------------------------------------------------------
// sobel_mag
// Four-stage magnitude unit: input register, squares and sum, root in two
// halves; rounding and clamp follow the last stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_mag
	import sobel_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       en,
	input  wire grad_t      gx,
	input  wire grad_t      gy,
	output logic [7:0]      mag
);

	grad_t        gx_s3;
	grad_t        gy_s3;
	logic [20:0]  sum_s4;
	logic         sat_s5;
	logic [33:0]  part_s5;
	logic         sat_s6;
	logic [16:0]  root_s6;
	logic signed [21:0] gxe;
	logic signed [21:0] gye;
	logic [7:0]   n;
	logic [8:0]   rem;

	assign gxe = 22'(gx_s3);
	assign gye = 22'(gy_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			gx_s3   <= gx;
			gy_s3   <= gy;
			sum_s4  <= 21'($unsigned(gxe * gxe) + $unsigned(gye * gye));
			sat_s5  <= (sum_s4 >= SAT_LEVEL);
			part_s5 <= isqrt_half({1'b0, sum_s4[15:0]}, 17'd0, 1'b1);
			sat_s6  <= sat_s5;
			root_s6 <= isqrt_lower(part_s5);
		end
	end

	assign n   = root_s6[7:0];
	assign rem = root_s6[16:8];

	// round to nearest: bump when the remainder passes the root
	always_comb begin
		if (sat_s6) begin
			mag = 8'd255;
		end else if (rem > {1'b0, n}) begin
			mag = (n == 8'd255) ? 8'd255 : n + 8'd1;
		end else begin
			mag = n;
		end
	end

endmodule

`default_nettype wire

// ----- tb/tb_sobel_edge_magnitude_rgb.sv -----
// ----------------------------------------------------------------------------
// tb_sobel_edge_magnitude_rgb
// Streams RGB frames of varied size through the Sobel magnitude block and
// compares every output word with a behavioral line-store and window model.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sobel_edge_magnitude_rgb;
	import sobel_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXW = 1024;
	localparam int WATCH_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} sobel_word_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        action;
	logic [7:0]  red_in;
	logic [7:0]  green_in;
	logic [7:0]  blue_in;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  red_out;
	logic [7:0]  green_out;
	logic [7:0]  blue_out;
	logic        frame_last;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	sobel_edge_magnitude_rgb #(.MAX_WIDTH(MAXW)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .action(action),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.frame_last(frame_last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// model state
	logic [10:0] width_reg;
	logic [12:0] height_reg;
	rgb_t        upper_line [MAXW];
	rgb_t        middle_line [MAXW];
	rgb_t        window [9];
	int unsigned col_pos;
	int unsigned row_pos;

	sobel_word_t expected_words [$];
	int          fail_count;
	int          idle_cycles;
	bit          quiet;
	bit          timed_out;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int unsigned active_width();
		if (width_reg == 0) return 1;
		if (width_reg > MAXW) return MAXW;
		return width_reg;
	endfunction

	function automatic int unsigned active_height();
		if (height_reg == 0) return 1;
		if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
		return height_reg;
	endfunction

	// rounded root, clamped at 255
	function automatic logic [7:0] edge_magnitude(int gx, int gy);
		int unsigned s;
		int unsigned n;
		s = gx * gx + gy * gy;
		if (s >= 65281) return 8'd255;
		n = 0;
		while ((n + 1) * (n + 1) <= s) n++;
		if (s - n * n > n) n++;
		return (n > 255) ? 8'd255 : n[7:0];
	endfunction

	task automatic predict_word(logic act, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned rr;
		int unsigned orow;
		int unsigned ocol;
		int          p [3][3];
		int          gx;
		int          gy;
		int          pr;
		int          pc;
		bit          have;
		rgb_t        pix;
		rgb_t        top;
		rgb_t        mid;
		sobel_word_t word;
		w = active_width();
		h = active_height();
		c = col_pos;
		rr = row_pos;
		have = 0;
		orow = 0;
		ocol = 0;
		if (c >= w) c = 0;
		pix = (act == ACT_FLUSH) ? 24'd0 : {r, g, b};
		top = upper_line[c];
		mid = middle_line[c];
		upper_line[c] = mid;
		middle_line[c] = pix;
		for (int k = 0; k < 3; k++) begin
			window[k] = window[3 + k];
			window[3 + k] = window[6 + k];
		end
		window[6] = top;
		window[7] = mid;
		window[8] = pix;
		if (c >= 1 && rr >= 1) begin
			have = 1; orow = rr - 1; ocol = c - 1;
		end else if (c == 0 && rr >= 2) begin
			have = 1; orow = rr - 2; ocol = w - 1;
		end
		if (have && orow >= h) have = 0;
		if (c + 1 >= w) begin
			c = 0; rr++;
		end else begin
			c++;
		end
		col_pos = c;
		row_pos = rr;
		if (!have) return;
		for (int ch = 0; ch < 3; ch++) begin
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++) begin
					pr = int'(orow) - 1 + k;
					pc = int'(ocol) - 1 + j;
					if (pr >= 0 && pr < int'(h) && pc >= 0 && pc < int'(w))
						p[k][j] = (window[j * 3 + k] >> (16 - 8 * ch)) & 8'hFF;
					else
						p[k][j] = 0;
				end
			end
			gx = (p[0][2] + 2 * p[1][2] + p[2][2]) - (p[0][0] + 2 * p[1][0] + p[2][0]);
			gy = (p[2][0] + 2 * p[2][1] + p[2][2]) - (p[0][0] + 2 * p[0][1] + p[0][2]);
			case (ch)
				0: word.red = edge_magnitude(gx, gy);
				1: word.green = edge_magnitude(gx, gy);
				default: word.blue = edge_magnitude(gx, gy);
			endcase
		end
		word.last = (orow == h - 1) && (ocol == w - 1);
		if (word.last) begin
			col_pos = 0;
			row_pos = 0;
		end
		expected_words.push_back(word);
	endtask

	// receiver side: stall in bursts, check each accepted word
	always @(posedge clk) begin
		sobel_word_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$error("unexpected output word %h %h %h last %b",
						red_out, green_out, blue_out, frame_last);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					if (red_out !== want.red) begin
						$error("red_out expected %0d actual %0d", want.red, red_out);
						fail_count++;
					end
					if (green_out !== want.green) begin
						$error("green_out expected %0d actual %0d", want.green, green_out);
						fail_count++;
					end
					if (blue_out !== want.blue) begin
						$error("blue_out expected %0d actual %0d", want.blue, blue_out);
						fail_count++;
					end
					if (frame_last !== want.last) begin
						$error("frame_last expected %0d actual %0d", want.last, frame_last);
						fail_count++;
					end
				end
			end
		end
	end

	int stall_left;
	always @(posedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog on cycles with no word accepted on either side and no register access
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("tb_sobel_edge_magnitude_rgb: FAIL");
			$finish;
		end
	end

	task automatic send_word(logic act, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		if (!quiet && $urandom_range(0, 6) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_word(act, r, g, b);
	endtask

	task automatic hold_input();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		hold_input();
		while (expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_WIDTH) width_reg = value[10:0];
		else height_reg = value[12:0];
		col_pos = 0;
		row_pos = 0;
	endtask

	task automatic set_frame(int unsigned w, int unsigned h);
		wait_drained();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
	endtask

	// one frame plus flush; kind 0 random, 1 all max, 2 all zero, 3 checker
	task automatic send_frame(int kind);
		int unsigned w;
		int unsigned h;
		logic [7:0]  v;
		w = active_width();
		h = active_height();
		for (int y = 0; y < h; y++) begin
			for (int x = 0; x < w; x++) begin
				case (kind)
					1: send_word(ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF);
					2: send_word(ACT_PIXEL, 8'h00, 8'h00, 8'h00);
					3: begin
						v = ((x + y) & 1) ? 8'hFF : 8'h00;
						send_word(ACT_PIXEL, v, ~v, v);
					end
					default: send_word(ACT_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
				endcase
			end
		end
		for (int i = 0; i <= w; i++)
			send_word(ACT_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic test_reset_size_tail();
		// default 1024-wide frame: run past the first row, then restart by writes
		for (int i = 0; i < MAXW + 8; i++)
			send_word(ACT_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic test_extremes();
		set_frame(3, 3);
		send_frame(1);
		send_frame(2);
		send_frame(3);
		set_frame(1, 1);
		send_frame(1);
		set_frame(0, 0);
		send_frame(0);
	endtask

	task automatic test_range_limits();
		set_frame(2047, 2);
		for (int i = 0; i < 16; i++)
			send_word(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom), 8'($urandom));
		set_frame(2, 8191);
		for (int i = 0; i < 40; i++)
			send_word(ACT_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic test_mixed_actions();
		set_frame(4, 3);
		for (int i = 0; i < 60; i++)
			send_word(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic test_random_frames();
		int sent;
		sent = 0;
		while (sent < 150) begin
			set_frame($urandom_range(1, 9), $urandom_range(1, 8));
			repeat ($urandom_range(1, 3)) begin
				send_frame(0);
				sent += (active_width() + 1) * (active_height() + 1);
			end
			if (sent > 100) quiet = 1;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_PIXEL;
		red_in = '0;
		green_in = '0;
		blue_in = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		fail_count = 0;
		idle_cycles = 0;
		quiet = 0;
		stall_left = 0;
		width_reg = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		col_pos = 0;
		row_pos = 0;
		for (int i = 0; i < MAXW; i++) begin
			upper_line[i] = '0;
			middle_line[i] = '0;
		end
		for (int i = 0; i < 9; i++) window[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_size_tail();
		test_extremes();
		test_range_limits();
		test_mixed_actions();
		test_random_frames();
		wait_drained();
		if (fail_count == 0)
			$display("tb_sobel_edge_magnitude_rgb: PASS");
		else
			$display("tb_sobel_edge_magnitude_rgb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sobel_edge_magnitude_rgb.f -----
rtl/core/sobel_pkg.sv
rtl/core/sobel_mag.sv
rtl/core/sobel_edge_magnitude_rgb.sv
tb/tb_sobel_edge_magnitude_rgb.sv
